>>> design/dqrv_pkg.sv
// Shared command, status and controller-to-datapath types for the deque block.
`timescale 1ns / 1ps

package dqrv_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_REMOVE     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Read offset relative to the head for the store's read port.
  typedef enum logic [1:0] {
    RD_HEAD,
    RD_NEXT,
    RD_SKIP
  } rd_sel_e;

  // Write address select for the store's write port.
  typedef enum logic [1:0] {
    WR_FRONT,
    WR_REAR,
    WR_GAP
  } wr_sel_e;

  typedef struct packed {
    logic    load_item;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    off_clr;
    logic    off_inc;
    logic    head_dec;
    logic    head_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
    status_e out_status;
    logic    out_pop;
  } dqrv_cmd_t;

  typedef struct packed {
    logic out_free;
    logic cnt_zero;
    logic cnt_full;
    logic match;
    logic scan_last;
  } dqrv_stat_t;

endpackage

>>> design/dqrv_dpath.sv
// Datapath: entry store, head and count registers, scan offset and output register.
`timescale 1ns / 1ps

module dqrv_dpath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  dqrv_pkg::dqrv_cmd_t                     cmd_i,
  output dqrv_pkg::dqrv_stat_t                    stat_o,
  input  logic signed [dqrv_pkg::DataW-1:0]       item_value_i,
  input  logic                                    out_ready_i,
  output logic                                    out_valid_o,
  output logic [1:0]                              status_o,
  output logic signed [dqrv_pkg::DataW-1:0]       popped_value_o,
  output logic [$clog2(DEPTH+1)-1:0]              entry_count_o
);
  import dqrv_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 2;
  localparam logic [SW-1:0] DepthS = SW'(DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  logic [DataW-1:0] mem [DEPTH];
  logic [DataW-1:0] rd_data_q;
  logic [DataW-1:0] val_q;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    off_q;
  logic             out_valid_q;
  status_e          status_q;
  logic [DataW-1:0] popped_q;
  logic [CW-1:0]    count_q;

  logic [SW-1:0]    rd_off, wr_off;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [DataW-1:0] wr_data;

  // Position of the entry that lies offset places behind the head.
  function automatic logic [AW-1:0] ring_pos(logic [AW-1:0] head, logic [SW-1:0] offset);
    logic [SW-1:0] sum;
    sum = SW'(head) + offset;
    if (sum >= DepthS) begin
      sum = sum - DepthS;
    end
    return sum[AW-1:0];
  endfunction

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_NEXT: rd_off = SW'(off_q) + SW'(1);
      RD_SKIP: rd_off = SW'(off_q) + SW'(2);
      default: rd_off = '0;
    endcase
    rd_addr = ring_pos(head_q, rd_off);
  end

  always_comb begin
    wr_off  = SW'(off_q);
    wr_data = rd_data_q;
    unique case (cmd_i.wr_sel)
      WR_FRONT: begin
        wr_addr = (head_q == '0) ? LastIdx : head_q - AW'(1);
        wr_data = val_q;
      end
      WR_REAR: begin
        wr_addr = ring_pos(head_q, SW'(cnt_q));
        wr_data = val_q;
      end
      default: wr_addr = ring_pos(head_q, wr_off);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      val_q <= item_value_i;
    end
  end

  always_comb begin
    head_d = head_q;
    if (cmd_i.head_dec) begin
      head_d = (head_q == '0) ? LastIdx : head_q - AW'(1);
    end else if (cmd_i.head_inc) begin
      head_d = (head_q == LastIdx) ? '0 : head_q + AW'(1);
    end
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= '0;
      off_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      if (cmd_i.off_clr) begin
        off_q <= '0;
      end else if (cmd_i.off_inc) begin
        off_q <= off_q + CW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q <= cmd_i.out_status;
      popped_q <= cmd_i.out_pop ? rd_data_q : '0;
      count_q  <= cnt_d;
    end
  end

  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.cnt_zero  = (cnt_q == '0);
  assign stat_o.cnt_full  = (cnt_q == DepthC);
  assign stat_o.match     = (rd_data_q == val_q);
  assign stat_o.scan_last = ((CW + 1)'(off_q) + (CW + 1)'(1)) == (CW + 1)'(cnt_q);

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign entry_count_o  = count_q;

endmodule

>>> design/dqrv_ctrl.sv
// Controller: state machine that sequences each command over the datapath.
`timescale 1ns / 1ps

module dqrv_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           cmd_i,
  input  dqrv_pkg::dqrv_stat_t stat_i,
  output dqrv_pkg::dqrv_cmd_t  cmd_o
);
  import dqrv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_F,
    S_PUSH_R,
    S_POP,
    S_SCAN,
    S_SHIFT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.rd_sel     = RD_HEAD;
    cmd_o.wr_sel     = WR_GAP;
    cmd_o.out_status = ST_OK;
    in_ready_o       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        // Keep the front entry in the read register for a pop or a scan.
        in_ready_o  = 1'b1;
        cmd_o.rd_en = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          cmd_o.off_clr   = 1'b1;
          unique case (cmd_e'(cmd_i))
            CMD_PUSH_FRONT: state_d = S_PUSH_F;
            CMD_PUSH_REAR:  state_d = S_PUSH_R;
            CMD_POP_FRONT:  state_d = S_POP;
            default:        state_d = S_SCAN;
          endcase
        end
      end
      S_PUSH_F, S_PUSH_R: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
          if (stat_i.cnt_full) begin
            cmd_o.out_status = ST_FULL;
          end else begin
            cmd_o.wr_en    = 1'b1;
            cmd_o.wr_sel   = (state_q == S_PUSH_F) ? WR_FRONT : WR_REAR;
            cmd_o.head_dec = (state_q == S_PUSH_F);
            cmd_o.cnt_inc  = 1'b1;
          end
        end
      end
      S_POP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
          if (stat_i.cnt_zero) begin
            cmd_o.out_status = ST_EMPTY;
          end else begin
            cmd_o.out_pop  = 1'b1;
            cmd_o.head_inc = 1'b1;
            cmd_o.cnt_dec  = 1'b1;
          end
        end
      end
      S_SCAN: begin
        priority if (stat_i.cnt_zero) begin
          if (stat_i.out_free) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_status = ST_EMPTY;
            state_d          = S_IDLE;
          end
        end else if (stat_i.match) begin
          // Fetch the entry behind the match; it moves into the gap next.
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_NEXT;
          state_d      = S_SHIFT;
        end else if (stat_i.scan_last) begin
          if (stat_i.out_free) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_status = ST_NOT_FOUND;
            state_d          = S_IDLE;
          end
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_sel  = RD_NEXT;
          cmd_o.off_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat_i.scan_last) begin
          if (stat_i.out_free) begin
            cmd_o.cnt_dec  = 1'b1;
            cmd_o.out_load = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = WR_GAP;
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_sel  = RD_SKIP;
          cmd_o.off_inc = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/deque_with_remove_by_value_core.sv
// Top level of the bounded deque of signed 32-bit values with remove by value.
`timescale 1ns / 1ps

// This block holds up to DEPTH signed 32-bit values in a ring store and takes one
// command per input beat: push at the front, push at the rear, pop from the front,
// or remove the first entry, counted from the front, that equals item_value_i.
// Every command returns exactly one output beat with a status (ok, empty, full,
// not found), the popped value (zero unless a pop succeeded) and the number of
// entries held after the command. A push into a full queue and a remove that
// finds nothing leave the queue unchanged. Commands run one at a time. The
// remove time is set by the store's single read port and single write port:
// the scan reads one entry per cycle, and closing the gap moves one entry per
// cycle. The output beat sits in a register, so the next command beat is
// accepted while the previous result still waits to be taken.

module deque_with_remove_by_value_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        cmd_i,
  input  logic signed [dqrv_pkg::DataW-1:0] item_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic signed [dqrv_pkg::DataW-1:0] popped_value_o,
  output logic [$clog2(DEPTH+1)-1:0]        entry_count_o
);
  import dqrv_pkg::*;

  dqrv_cmd_t  dp_cmd;
  dqrv_stat_t dp_stat;

  // The controller steps through each command; of the datapath it sees only status flags.
  dqrv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // The datapath owns the store, the head and count, and the output register.
  dqrv_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .item_value_i   (item_value_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .entry_count_o  (entry_count_o)
  );

endmodule
